[rtl/core/ivsc_pkg.sv]
// Shared types and constants of the idle valve step controller.
`default_nettype none
package ivsc_pkg;

  localparam int TEMP_W = 16;
  localparam int POS_W  = 10;
  localparam int CNT_W  = 8;
  localparam int ERR_W  = 12;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_OPEN  = 2'd1,
    ACT_CLOSE = 2'd2,
    ACT_STOP  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    REG_PERIOD_TICKS = 3'd0,
    REG_CALIB_TICKS  = 3'd1,
    REG_STEP_LIMIT   = 3'd2,
    REG_DEADBAND     = 3'd3,
    REG_WORK_POWER   = 3'd4,
    REG_CALIB_POWER  = 3'd5
  } reg_index_t;

  localparam logic [CNT_W-1:0] RST_PERIOD_TICKS = 8'd2;
  localparam logic [CNT_W-1:0] RST_CALIB_TICKS  = 8'd15;
  localparam logic [POS_W-1:0] RST_STEP_LIMIT   = 10'd30;
  localparam logic [POS_W-1:0] RST_DEADBAND     = 10'd20;
  localparam logic [POS_W-1:0] RST_WORK_POWER   = 10'd700;
  localparam logic [POS_W-1:0] RST_CALIB_POWER  = 10'd1000;

  localparam logic [POS_W-1:0] FULL_OPEN = 10'd1000;
  localparam logic [CNT_W-1:0] CNT_MAX   = 8'd255;

  localparam logic signed [TEMP_W-1:0] TEMP_COLD  = 16'sd40;
  localparam logic signed [TEMP_W-1:0] TEMP_COOL  = 16'sd50;
  localparam logic signed [TEMP_W-1:0] TEMP_WARM  = 16'sd70;
  localparam logic signed [TEMP_W-1:0] TEMP_HOT   = 16'sd85;

  localparam logic [POS_W-1:0] TARGET_COLD = 10'd1000;
  localparam logic [POS_W-1:0] TARGET_COOL = 10'd800;
  localparam logic [POS_W-1:0] TARGET_WARM = 10'd500;
  localparam logic [POS_W-1:0] TARGET_HOT  = 10'd300;
  localparam logic [POS_W-1:0] TARGET_IDLE = 10'd250;

  typedef struct packed {
    logic [CNT_W-1:0] period_ticks;
    logic [CNT_W-1:0] calib_ticks;
    logic [POS_W-1:0] step_limit;
    logic [POS_W-1:0] deadband;
    logic [POS_W-1:0] work_power;
    logic [POS_W-1:0] calib_power;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] valve_position;
    logic [CNT_W-1:0] period_count;
    logic [CNT_W-1:0] calib_count;
    logic             is_calibrated;
  } state_t;

  typedef struct packed {
    action_t          action;
    logic [POS_W-1:0] drive;
    logic [POS_W-1:0] position;
    logic             calibrated;
  } result_t;

endpackage
`default_nettype wire

[rtl/core/ivsc_regs.sv]
// APB configuration registers of the idle valve step controller.
`default_nettype none
module ivsc_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ivsc_pkg::ADDR_W-1:0]     paddr,
  input  logic [ivsc_pkg::DATA_W-1:0]     pwdata,
  output logic [ivsc_pkg::DATA_W-1:0]     prdata,
  output logic                            pready,
  output ivsc_pkg::cfg_t                  cfg
);

  ivsc_pkg::reg_index_t sel;
  logic                 wr_en;

  assign sel    = ivsc_pkg::reg_index_t'(paddr[ivsc_pkg::ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_ticks <= ivsc_pkg::RST_PERIOD_TICKS;
      cfg.calib_ticks  <= ivsc_pkg::RST_CALIB_TICKS;
      cfg.step_limit   <= ivsc_pkg::RST_STEP_LIMIT;
      cfg.deadband     <= ivsc_pkg::RST_DEADBAND;
      cfg.work_power   <= ivsc_pkg::RST_WORK_POWER;
      cfg.calib_power  <= ivsc_pkg::RST_CALIB_POWER;
    end else if (wr_en) begin
      unique case (sel)
        ivsc_pkg::REG_PERIOD_TICKS: cfg.period_ticks <= pwdata[ivsc_pkg::CNT_W-1:0];
        ivsc_pkg::REG_CALIB_TICKS:  cfg.calib_ticks  <= pwdata[ivsc_pkg::CNT_W-1:0];
        ivsc_pkg::REG_STEP_LIMIT:   cfg.step_limit   <= pwdata[ivsc_pkg::POS_W-1:0];
        ivsc_pkg::REG_DEADBAND:     cfg.deadband     <= pwdata[ivsc_pkg::POS_W-1:0];
        ivsc_pkg::REG_WORK_POWER:   cfg.work_power   <= pwdata[ivsc_pkg::POS_W-1:0];
        ivsc_pkg::REG_CALIB_POWER:  cfg.calib_power  <= pwdata[ivsc_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (sel)
      ivsc_pkg::REG_PERIOD_TICKS: prdata = {24'd0, cfg.period_ticks};
      ivsc_pkg::REG_CALIB_TICKS:  prdata = {24'd0, cfg.calib_ticks};
      ivsc_pkg::REG_STEP_LIMIT:   prdata = {22'd0, cfg.step_limit};
      ivsc_pkg::REG_DEADBAND:     prdata = {22'd0, cfg.deadband};
      ivsc_pkg::REG_WORK_POWER:   prdata = {22'd0, cfg.work_power};
      ivsc_pkg::REG_CALIB_POWER:  prdata = {22'd0, cfg.calib_power};
      default:                    prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/ivsc_decide.sv]
// Per-tick decision logic: calibration and position control for one item.
`default_nettype none
module ivsc_decide (
  input  ivsc_pkg::cfg_t                      cfg,
  input  ivsc_pkg::state_t                    state,
  input  logic signed [ivsc_pkg::TEMP_W-1:0]  temperature,
  output ivsc_pkg::state_t                    state_next,
  output ivsc_pkg::result_t                   result
);

  logic [ivsc_pkg::POS_W-1:0]        target;
  logic signed [ivsc_pkg::ERR_W-1:0] err;
  logic signed [ivsc_pkg::ERR_W-1:0] band;
  logic [ivsc_pkg::ERR_W-1:0]        err_abs;
  logic [ivsc_pkg::POS_W-1:0]        mag;
  logic [ivsc_pkg::CNT_W-1:0]        calib_inc;
  logic [ivsc_pkg::CNT_W-1:0]        period_inc;

  // Target position from temperature thresholds.
  always_comb begin
    priority if (temperature < ivsc_pkg::TEMP_COLD) target = ivsc_pkg::TARGET_COLD;
    else if (temperature < ivsc_pkg::TEMP_COOL)     target = ivsc_pkg::TARGET_COOL;
    else if (temperature < ivsc_pkg::TEMP_WARM)     target = ivsc_pkg::TARGET_WARM;
    else if (temperature < ivsc_pkg::TEMP_HOT)      target = ivsc_pkg::TARGET_HOT;
    else                                            target = ivsc_pkg::TARGET_IDLE;
  end

  assign err     = $signed({2'b00, target}) - $signed({2'b00, state.valve_position});
  assign band    = $signed({2'b00, cfg.deadband});
  assign err_abs = err[ivsc_pkg::ERR_W-1] ? ivsc_pkg::ERR_W'(-err) : ivsc_pkg::ERR_W'(err);
  // Limit the move to the step limit; step_limit fits in the position width.
  assign mag = (err_abs > {2'b00, cfg.step_limit}) ? cfg.step_limit
                                                   : err_abs[ivsc_pkg::POS_W-1:0];

  assign calib_inc  = (state.calib_count == ivsc_pkg::CNT_MAX) ? state.calib_count
                                                               : state.calib_count + 1'b1;
  assign period_inc = (state.period_count == ivsc_pkg::CNT_MAX) ? state.period_count
                                                                 : state.period_count + 1'b1;

  always_comb begin
    state_next    = state;
    result.action = ivsc_pkg::ACT_NONE;
    result.drive  = '0;
    if (!state.is_calibrated) begin
      state_next.calib_count = calib_inc;
      if (calib_inc == ivsc_pkg::CNT_W'(1)) begin
        result.action = ivsc_pkg::ACT_OPEN;
        result.drive  = cfg.calib_power;
      end
      // Finishing wins over the opening on the same tick.
      if (calib_inc >= cfg.calib_ticks) begin
        result.action            = ivsc_pkg::ACT_STOP;
        result.drive             = '0;
        state_next.valve_position = ivsc_pkg::FULL_OPEN;
        state_next.is_calibrated  = 1'b1;
      end
    end else begin
      state_next.period_count = period_inc;
      if (period_inc >= cfg.period_ticks) begin
        state_next.period_count = '0;
        priority if (err > band) begin
          result.action             = ivsc_pkg::ACT_OPEN;
          result.drive              = cfg.work_power;
          state_next.valve_position = state.valve_position + mag;
        end else if (err < -band) begin
          result.action             = ivsc_pkg::ACT_CLOSE;
          result.drive              = cfg.work_power;
          state_next.valve_position = state.valve_position - mag;
        end else begin
          result.action = ivsc_pkg::ACT_STOP;
        end
      end
    end
    result.position   = state_next.valve_position;
    result.calibrated = state_next.is_calibrated;
  end

endmodule
`default_nettype wire

[rtl/core/idle_valve_step_controller_core.sv]
// Top level of the idle valve step controller: input register, decision, result register.
// A tick accepted into the input register moves into the result register when that slot
// is free; one tick is accepted per cycle while the result side does not stall, as
// position and counters are updated combinationally between the two registers.
// A stalled result holds the input register and then drops in_ready.
// Reset (synchronous, active high) loads the default configuration, sets the
// position to full open, clears both counters and the calibrated flag, and
// empties both registers.
`default_nettype none
module idle_valve_step_controller_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ivsc_pkg::ADDR_W-1:0]        paddr,
  input  logic [ivsc_pkg::DATA_W-1:0]        pwdata,
  output logic [ivsc_pkg::DATA_W-1:0]        prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [ivsc_pkg::TEMP_W-1:0] temperature,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         action,
  output logic [ivsc_pkg::POS_W-1:0]         drive,
  output logic [ivsc_pkg::POS_W-1:0]         position,
  output logic                               calibrated
);

  ivsc_pkg::cfg_t                     cfg;
  ivsc_pkg::state_t                   state;
  ivsc_pkg::state_t                   state_next;
  ivsc_pkg::result_t                  result_next;
  ivsc_pkg::result_t                  result;
  logic                               in_full;
  logic signed [ivsc_pkg::TEMP_W-1:0] temp_q;
  logic                               advance;

  ivsc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ivsc_decide u_decide (
    .cfg         (cfg),
    .state       (state),
    .temperature (temp_q),
    .state_next  (state_next),
    .result      (result_next)
  );

  // Move the held item into the result register when that slot is free.
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      temp_q <= temperature;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.valve_position <= ivsc_pkg::FULL_OPEN;
      state.period_count   <= '0;
      state.calib_count    <= '0;
      state.is_calibrated  <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign action     = result.action;
  assign drive      = result.drive;
  assign position   = result.position;
  assign calibrated = result.calibrated;

endmodule
`default_nettype wire

[verif/tb_idle_valve_step_controller_core.sv]
// Self-checking testbench for the idle valve step controller core.
module tb_idle_valve_step_controller_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ivsc_pkg::*;

  // Tracks the controller's position and counters and holds the results still to come.
  class valve_scoreboard;
    cfg_t    cfg;
    state_t  st;
    result_t due[$];
    int      errors;

    function new();
      cfg.period_ticks = RST_PERIOD_TICKS;
      cfg.calib_ticks  = RST_CALIB_TICKS;
      cfg.step_limit   = RST_STEP_LIMIT;
      cfg.deadband     = RST_DEADBAND;
      cfg.work_power   = RST_WORK_POWER;
      cfg.calib_power  = RST_CALIB_POWER;
      st.valve_position = FULL_OPEN;
      st.period_count   = '0;
      st.calib_count    = '0;
      st.is_calibrated  = 1'b0;
      errors = 0;
    endfunction

    function void set_register(reg_index_t idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_PERIOD_TICKS: cfg.period_ticks = value[CNT_W-1:0];
        REG_CALIB_TICKS:  cfg.calib_ticks  = value[CNT_W-1:0];
        REG_STEP_LIMIT:   cfg.step_limit   = value[POS_W-1:0];
        REG_DEADBAND:     cfg.deadband     = value[POS_W-1:0];
        REG_WORK_POWER:   cfg.work_power   = value[POS_W-1:0];
        REG_CALIB_POWER:  cfg.calib_power  = value[POS_W-1:0];
        default: ;
      endcase
    endfunction

    function result_t predict_tick(logic signed [TEMP_W-1:0] temp);
      result_t          r;
      logic [POS_W-1:0] goal;
      logic [POS_W-1:0] mag;
      int               err;
      r.action = ACT_NONE;
      r.drive  = '0;
      if (!st.is_calibrated) begin
        if (st.calib_count != CNT_MAX) st.calib_count++;
        if (st.calib_count == 8'd1) begin
          r.action = ACT_OPEN;
          r.drive  = cfg.calib_power;
        end
        // finishing wins over the first-tick opening
        if (st.calib_count >= cfg.calib_ticks) begin
          r.action = ACT_STOP;
          r.drive  = '0;
          st.valve_position = FULL_OPEN;
          st.is_calibrated  = 1'b1;
        end
      end else begin
        if (st.period_count != CNT_MAX) st.period_count++;
        if (st.period_count >= cfg.period_ticks) begin
          st.period_count = '0;
          if (temp < TEMP_COLD)      goal = TARGET_COLD;
          else if (temp < TEMP_COOL) goal = TARGET_COOL;
          else if (temp < TEMP_WARM) goal = TARGET_WARM;
          else if (temp < TEMP_HOT)  goal = TARGET_HOT;
          else                       goal = TARGET_IDLE;
          err = int'(goal) - int'(st.valve_position);
          mag = (err < 0) ? POS_W'(-err) : POS_W'(err);
          if (mag > cfg.step_limit) mag = cfg.step_limit;
          if (err > int'(cfg.deadband)) begin
            r.action = ACT_OPEN;
            r.drive  = cfg.work_power;
            st.valve_position = st.valve_position + mag;
          end else if (err < -int'(cfg.deadband)) begin
            r.action = ACT_CLOSE;
            r.drive  = cfg.work_power;
            st.valve_position = st.valve_position - mag;
          end else begin
            r.action = ACT_STOP;
          end
        end
      end
      r.position   = st.valve_position;
      r.calibrated = st.is_calibrated;
      return r;
    endfunction

    function void note_tick(logic signed [TEMP_W-1:0] temp);
      due.push_back(predict_tick(temp));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due.size() == 0) begin
        $display("%0t: result with none expected: action %0d drive %0d position %0d cal %0d",
                 $time, got.action, got.drive, got.position, got.calibrated);
        errors++;
        return;
      end
      want = due.pop_front();
      if (got.action != want.action) begin
        $display("%0t: action expected %0d got %0d", $time, want.action, got.action);
        errors++;
      end
      if (got.drive != want.drive) begin
        $display("%0t: drive expected %0d got %0d", $time, want.drive, got.drive);
        errors++;
      end
      if (got.position != want.position) begin
        $display("%0t: position expected %0d got %0d", $time, want.position, got.position);
        errors++;
      end
      if (got.calibrated != want.calibrated) begin
        $display("%0t: calibrated expected %0d got %0d", $time, want.calibrated,
                 got.calibrated);
        errors++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst         = 1'b1;
  logic                      psel        = 1'b0;
  logic                      penable     = 1'b0;
  logic                      pwrite      = 1'b0;
  logic [ADDR_W-1:0]         paddr       = '0;
  logic [DATA_W-1:0]         pwdata      = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;
  logic                      in_valid    = 1'b0;
  logic                      in_ready;
  logic signed [TEMP_W-1:0]  temperature = '0;
  logic                      out_valid;
  logic                      out_ready   = 1'b0;
  logic [1:0]                action;
  logic [POS_W-1:0]          drive;
  logic [POS_W-1:0]          position;
  logic                      calibrated;

  valve_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asks = 0;

  idle_valve_step_controller_core uut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .temperature (temperature),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .action      (action),
    .drive       (drive),
    .position    (position),
    .calibrated  (calibrated)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb_idle_valve_step_controller_core NOT OK");
    $finish;
  end

  // Result side: random stalls, plus a long hold whenever one is asked for.
  initial begin
    int hold_left;
    int holds_done;
    hold_left = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_asks) begin
        holds_done = hold_asks;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : watch_results
    result_t got;
    if (!rst && out_valid && out_ready) begin
      got.action     = action_t'(action);
      got.drive      = drive;
      got.position   = position;
      got.calibrated = calibrated;
      sb.check_result(got);
    end
  end

  task automatic write_reg(reg_index_t idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_tick(logic signed [TEMP_W-1:0] temp);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    temperature <= temp;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(temp);
  endtask

  // Drop valid and drain every pending result so registers can be written.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_setup(logic [7:0] period, logic [7:0] calib, logic [9:0] step,
                             logic [9:0] dead, logic [9:0] work, logic [9:0] cpow);
    write_reg(REG_PERIOD_TICKS, {24'd0, period});
    write_reg(REG_CALIB_TICKS,  {24'd0, calib});
    write_reg(REG_STEP_LIMIT,   {22'd0, step});
    write_reg(REG_DEADBAND,     {22'd0, dead});
    write_reg(REG_WORK_POWER,   {22'd0, work});
    write_reg(REG_CALIB_POWER,  {22'd0, cpow});
  endtask

  initial begin
    static logic signed [TEMP_W-1:0] warmup[4]  = '{-16'sd32768, 16'sd32767, 16'sd0,
                                                    -16'sd1};
    static logic signed [TEMP_W-1:0] ladder[11] = '{16'sd100, 16'sd39, 16'sd40, 16'sd49,
                                                    16'sd50, 16'sd69, 16'sd70, 16'sd84,
                                                    16'sd85, 16'sd32767, -16'sd32768};
    logic signed [TEMP_W-1:0] t;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Calibration: long count, first tick opens at full calibration power.
    write_reg(REG_CALIB_TICKS, 32'd255);
    write_reg(REG_CALIB_POWER, 32'd1023);
    write_reg(REG_WORK_POWER, 32'd1023);
    foreach (warmup[i]) send_tick(warmup[i]);
    settle();

    // Cut calibration short, then walk every temperature threshold with
    // a decision on each tick and unlimited steps.
    write_reg(REG_CALIB_TICKS, 32'd1);
    write_reg(REG_PERIOD_TICKS, 32'd0);
    write_reg(REG_DEADBAND, 32'd0);
    write_reg(REG_STEP_LIMIT, 32'd1023);
    foreach (ladder[i]) send_tick(ladder[i]);
    settle();

    // Zero step limit: actions still given, position holds.
    write_reg(REG_STEP_LIMIT, 32'd0);
    send_tick(16'sd85);
    send_tick(16'sd0);
    settle();

    write_reg(REG_DEADBAND, 32'd1023);
    send_tick(16'sd85);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: apply_setup(8'd1, 8'd0, 10'd1, 10'd0, 10'd0, 10'd0);
        1: apply_setup(8'd0, 8'd255, 10'd1023, 10'd0, 10'd1023, 10'd1023);
        2: apply_setup(8'd255, 8'd2, 10'd30, 10'd20, 10'd700, 10'd1000);
        3: apply_setup(8'($urandom), 8'($urandom), 10'($urandom), 10'($urandom),
                       10'($urandom), 10'($urandom));
        4: apply_setup(8'($urandom_range(0, 3)), 8'($urandom), 10'($urandom_range(0, 200)),
                       10'($urandom_range(0, 60)), 10'($urandom), 10'($urandom));
        default: apply_setup(8'd2, 8'd15, 10'd30, 10'd1023, 10'd700, 10'd1000);
      endcase
      case (ph % 4)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 48; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 48; end
        default: begin send_idle_pct <= 9; recv_stall_pct <= 9; end
      endcase
      // back up the output and keep offering items into the stall
      if (ph == 0) hold_asks <= hold_asks + 1;
      for (int n = 0; n < 300; n++) begin
        if ($urandom_range(0, 4) == 0) t = TEMP_W'($urandom);
        else t = $signed(TEMP_W'($urandom_range(0, 140))) - 16'sd20;
        send_tick(t);
      end
      settle();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("tb_idle_valve_step_controller_core OK");
    end else begin
      $display("tb_idle_valve_step_controller_core NOT OK");
    end
    $finish;
  end

endmodule
